// ----- hdl/dpfd_pkg.sv -----
// Shared types, constants and the segment decode table for the desk panel
// frame decoder. Used by every module in hdl/; depends on nothing else.
`timescale 1ns / 1ps

package dpfd_pkg;

	localparam int FRAME_BYTES_DEF = 6;
	localparam int CNT_W           = 4;
	localparam int QUEUE_DEPTH     = 2;
	localparam logic [7:0] HEADER_RESET = 8'h5a;

	localparam logic [6:0] CH_ZERO     = 7'h30;
	localparam logic [6:0] CH_NINE     = 7'h39;
	localparam logic [6:0] CH_FIVE     = 7'h35;
	localparam logic [6:0] CH_DASH     = 7'h2d;
	localparam logic [6:0] CH_S        = 7'h53;
	localparam logic [6:0] CH_QUESTION = 7'h3f;

	// One assembled frame as handed from the front end to the decoder.
	typedef struct packed {
		logic       ok;
		logic [7:0] seg_l;
		logic [7:0] seg_m;
		logic [7:0] seg_r;
	} frame_rec_t;

	function automatic logic [6:0] seg_to_ascii(input logic [7:0] pattern);
		logic [6:0] c;
		unique case (pattern[6:0])
			7'h3f:   c = 7'h30;
			7'h06:   c = 7'h31;
			7'h5b:   c = 7'h32;
			7'h4f:   c = 7'h33;
			7'h66:   c = 7'h34;
			7'h6d:   c = 7'h35;
			7'h7d:   c = 7'h36;
			7'h07:   c = 7'h37;
			7'h7f:   c = 7'h38;
			7'h6f:   c = 7'h39;
			7'h40:   c = CH_DASH;
			7'h79:   c = 7'h45;
			7'h50:   c = 7'h72;
			7'h31:   c = 7'h54;
			7'h76:   c = 7'h48;
			7'h5c:   c = 7'h6f;
			7'h78:   c = 7'h74;
			7'h00:   c = 7'h20;
			default: c = CH_QUESTION;
		endcase
		return c;
	endfunction

endpackage

// ----- hdl/dpfd_front.sv -----
// Front end: holds the header register, counts bytes into a frame, keeps the
// running sum and the three payload bytes. Depends on dpfd_pkg.
`timescale 1ns / 1ps

module dpfd_front #(
	parameter int FRAME_BYTES = dpfd_pkg::FRAME_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [7:0]            cfg_data,
	input  logic                  accept,
	input  logic [7:0]            rx_byte,
	output logic                  rec_push,
	output dpfd_pkg::frame_rec_t  rec
);

	localparam logic [dpfd_pkg::CNT_W-1:0] LAST_POS = dpfd_pkg::CNT_W'(FRAME_BYTES);
	localparam logic [dpfd_pkg::CNT_W-1:0] POS_ONE  = dpfd_pkg::CNT_W'(1);
	localparam logic [dpfd_pkg::CNT_W-1:0] POS_TWO  = dpfd_pkg::CNT_W'(2);
	localparam logic [dpfd_pkg::CNT_W-1:0] POS_FOUR = dpfd_pkg::CNT_W'(4);

	logic [7:0]                header_q;
	logic [dpfd_pkg::CNT_W-1:0] cnt_q;
	logic [7:0]                sum_q;
	logic [7:0]                pay_q [3];
	logic [dpfd_pkg::CNT_W-1:0] pos;
	logic                      is_header;
	logic                      in_frame;

	assign pos       = cnt_q + POS_ONE;
	assign is_header = (rx_byte == header_q);
	assign in_frame  = (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= dpfd_pkg::HEADER_RESET;
		end else if (cfg_we) begin
			header_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sum_q <= '0;
		end else if (accept) begin
			if (is_header) begin
				cnt_q <= POS_ONE;
				sum_q <= '0;
			end else if (in_frame) begin
				if (pos == LAST_POS) begin
					cnt_q <= '0;
				end else begin
					cnt_q <= pos;
					sum_q <= sum_q + rx_byte;
				end
			end
		end
	end

	// The first three bytes after the header are the display patterns.
	always_ff @(posedge clk) begin
		if (accept && !is_header && in_frame && pos != LAST_POS &&
		    pos >= POS_TWO && pos <= POS_FOUR) begin
			pay_q[2'(pos - POS_TWO)] <= rx_byte;
		end
	end

	assign rec_push  = accept && !is_header && in_frame && (pos == LAST_POS);
	assign rec.ok    = (sum_q == rx_byte);
	assign rec.seg_l = pay_q[0];
	assign rec.seg_m = pay_q[1];
	assign rec.seg_r = pay_q[2];

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < LAST_POS)
		else $error("byte count reached the frame length");
`endif

endmodule

// ----- hdl/dpfd_queue.sv -----
// Short frame queue between the front end and the decoder.
// Depends on dpfd_pkg for the record type and the depth.
`timescale 1ns / 1ps

module dpfd_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr,
	input  dpfd_pkg::frame_rec_t  wr_data,
	input  logic                  rd,
	output dpfd_pkg::frame_rec_t  rd_data,
	output logic                  not_empty,
	output logic                  full
);

	localparam int DEPTH = dpfd_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	dpfd_pkg::frame_rec_t entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == CNT_FULL);
	assign rd_data   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !wr)
		else $error("frame written into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd |-> not_empty)
		else $error("frame read from an empty queue");
`endif

endmodule

// ----- hdl/dpfd_back.sv -----
// Decoder: turns a frame record into characters and a height, keeps the
// height and holds the result register. Depends on dpfd_pkg.
`timescale 1ns / 1ps

module dpfd_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rec_valid,
	input  dpfd_pkg::frame_rec_t  rec,
	output logic                  rec_take,
	input  logic                  pop,
	output logic                  empty,
	output logic                  checksum_ok,
	output logic [7:0]            seg_left,
	output logic [7:0]            seg_middle,
	output logic [7:0]            seg_right,
	output logic [6:0]            char_left,
	output logic [6:0]            char_middle,
	output logic [6:0]            char_right,
	output logic                  has_point,
	output logic [13:0]           height_value,
	output logic                  height_updated
);

	logic        out_v_q;
	logic [13:0] kept_q;
	logic        ok_q, point_q, upd_q;
	logic [7:0]  seg_l_q, seg_m_q, seg_r_q;
	logic [6:0]  ch_l_q, ch_m_q, ch_r_q;

	logic [6:0]  cl, cm, cr;
	logic [3:0]  dl, dm, dr;
	logic        all_digits, point;
	logic [13:0] h_base, h;
	logic        upd;

	assign empty    = !out_v_q;
	assign rec_take = rec_valid && (!out_v_q || pop);

	always_comb begin
		cm = dpfd_pkg::seg_to_ascii(rec.seg_m);
		cr = dpfd_pkg::seg_to_ascii(rec.seg_r);
		cl = dpfd_pkg::seg_to_ascii(rec.seg_l);
		// A five ahead of a dash is really an S on the panel.
		if (cm == dpfd_pkg::CH_DASH && cl == dpfd_pkg::CH_FIVE) begin
			cl = dpfd_pkg::CH_S;
		end
	end

	assign point      = rec.seg_m[7];
	assign all_digits = (cl >= dpfd_pkg::CH_ZERO) && (cl <= dpfd_pkg::CH_NINE) &&
	                    (cm >= dpfd_pkg::CH_ZERO) && (cm <= dpfd_pkg::CH_NINE) &&
	                    (cr >= dpfd_pkg::CH_ZERO) && (cr <= dpfd_pkg::CH_NINE);
	assign dl = 4'(cl - dpfd_pkg::CH_ZERO);
	assign dm = 4'(cm - dpfd_pkg::CH_ZERO);
	assign dr = 4'(cr - dpfd_pkg::CH_ZERO);

	// Without a decimal point the display shows whole units, so scale by ten.
	assign h_base = 14'(dl) * 14'd100 + 14'(dm) * 14'd10 + 14'(dr);
	assign h      = point ? h_base : h_base * 14'd10;
	assign upd    = rec.ok && all_digits && (h != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			kept_q  <= '0;
		end else begin
			if (rec_take) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
			if (rec_take && upd) begin
				kept_q <= h;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rec_take) begin
			ok_q    <= rec.ok;
			seg_l_q <= rec.ok ? rec.seg_l : 8'h00;
			seg_m_q <= rec.ok ? rec.seg_m : 8'h00;
			seg_r_q <= rec.ok ? rec.seg_r : 8'h00;
			ch_l_q  <= rec.ok ? cl : 7'h00;
			ch_m_q  <= rec.ok ? cm : 7'h00;
			ch_r_q  <= rec.ok ? cr : 7'h00;
			point_q <= rec.ok && point;
			upd_q   <= upd;
		end
	end

	assign checksum_ok    = ok_q;
	assign seg_left       = seg_l_q;
	assign seg_middle     = seg_m_q;
	assign seg_right      = seg_r_q;
	assign char_left      = ch_l_q;
	assign char_middle    = ch_m_q;
	assign char_right     = ch_r_q;
	assign has_point      = point_q;
	assign height_value   = kept_q;
	assign height_updated = upd_q;

`ifndef SYNTHESIS
	a_upd_good: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && upd_q) |-> (ok_q && kept_q != '0))
		else $error("height update on a bad frame or to zero");
	a_kept_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(rec_take && upd) |=> $stable(kept_q))
		else $error("kept height changed without an update");
`endif

endmodule

// ----- hdl/desk_panel_frame_decoder.sv -----
// Top level of the desk panel frame decoder: header register, frame front
// end, frame queue and decoder. Depends on dpfd_pkg, dpfd_front, dpfd_queue
// and dpfd_back.
//
// Usage: received link bytes are written like a queue (push while full is
// low). A header byte always starts a new frame; a frame is FRAME_BYTES
// bytes including the header. For every completed frame one result appears
// on the result side, read like a queue (data valid while empty is low,
// taken with pop). Bytes outside a frame produce nothing.
// The record of a frame passes through the frame queue into the result
// register before the result is visible. Bytes are taken at one per cycle
// while full is low; results leave at one per cycle while pop is high and
// frames wait. A two-entry frame queue plus the result register part the
// front end and decoder, so full rises only after three undelivered results are held while pop stays low.
// Reset clears the byte count, sum, kept height and all queues; the header
// register returns to 0x5a. cfg_we writes the header register at once.
`timescale 1ns / 1ps

module desk_panel_frame_decoder #(
	parameter int FRAME_BYTES = dpfd_pkg::FRAME_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_data,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic        checksum_ok,
	output logic [7:0]  seg_left,
	output logic [7:0]  seg_middle,
	output logic [7:0]  seg_right,
	output logic [6:0]  char_left,
	output logic [6:0]  char_middle,
	output logic [6:0]  char_right,
	output logic        has_point,
	output logic [13:0] height_value,
	output logic        height_updated
);

	logic                 accept;
	logic                 rec_push;
	dpfd_pkg::frame_rec_t rec_in;
	dpfd_pkg::frame_rec_t rec_out;
	logic                 rec_valid;
	logic                 rec_take;

	assign accept = push && !full;

	dpfd_front #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.accept   (accept),
		.rx_byte  (rx_byte),
		.rec_push (rec_push),
		.rec      (rec_in)
	);

	dpfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (rec_push),
		.wr_data   (rec_in),
		.rd        (rec_take),
		.rd_data   (rec_out),
		.not_empty (rec_valid),
		.full      (full)
	);

	dpfd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.rec_valid      (rec_valid),
		.rec            (rec_out),
		.rec_take       (rec_take),
		.pop            (pop),
		.empty          (empty),
		.checksum_ok    (checksum_ok),
		.seg_left       (seg_left),
		.seg_middle     (seg_middle),
		.seg_right      (seg_right),
		.char_left      (char_left),
		.char_middle    (char_middle),
		.char_right     (char_right),
		.has_point      (has_point),
		.height_value   (height_value),
		.height_updated (height_updated)
	);

endmodule
